[hdl/vcdg_pkg.sv]
// Shared types, constants and helper functions of the volume gradient block.
package vcdg_pkg;

  localparam int MAX_VOXELS = 32768;
  localparam int MAX_DIM    = 32;
  localparam int IDX_W      = 15;
  localparam int SMP_W      = 16;
  localparam int DIM_W      = 6;
  localparam int SP_W       = 16;
  localparam int GMAG_W     = 28;
  localparam int SUM_W      = 58;
  localparam int DIV_W      = 46;
  localparam int DVS_W      = 32;
  localparam int STEP_W     = 6;
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z = 3'd5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STEP_W-1:0] STEPS_COORD = 6'd15;
  localparam logic [STEP_W-1:0] STEPS_GRAD  = 6'd29;
  localparam logic [STEP_W-1:0] STEPS_BIAS  = 6'd46;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  // Size register as used: zero counts as one, anything above the limit is clamped.
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // Biases a normalized magnitude into [0,1] Q0.16 with saturation.
  function automatic logic [15:0] bias_out(input logic [DIV_W-1:0] q, input logic neg);
    logic [16:0] qs;
    logic [17:0] up;
    logic [15:0] r;
    qs = (q > DIV_W'(65536)) ? 17'd65536 : q[16:0];
    up = 18'd32768 + {1'b0, qs};
    if (neg) r = (qs > 17'd32768) ? 16'd0 : 16'(17'd32768 - qs);
    else r = (up > 18'd65535) ? 16'hFFFF : up[15:0];
    return r;
  endfunction

endpackage

[hdl/vcdg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vcdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/vcdg_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module vcdg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vcdg_pkg::div_req_t req,
  output vcdg_pkg::div_rsp_t rsp
);
  import vcdg_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dq_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  // The dividend is left-aligned so that only the requested number of bits is walked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        dq_r   <= req.dividend << (STEP_W'(DIV_W) - req.steps);
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        dq_r  <= {dq_r[DIV_W-2:0], fits};
        rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;
  assign rsp.rem  = rem_r;

endmodule

[hdl/vcdg_sqrt.sv]
// Integer square root, two radicand bits per cycle.
module vcdg_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  vcdg_pkg::sqrt_req_t req,
  output vcdg_pkg::sqrt_rsp_t rsp
);
  import vcdg_pkg::*;

  logic            busy_r;
  logic            done_r;
  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] tb;
  logic            ge;

  assign tb = res_r + bit_r;
  assign ge = v_r >= tb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        v_r    <= req.value;
        res_r  <= '0;
        bit_r  <= {2'b01, {(SQ_W-2){1'b0}}};
      end else if (busy_r) begin
        if (ge) begin
          v_r   <= v_r - tb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[ROOT_W-1:0];

endmodule

[hdl/volume_central_difference_gradient.sv]
// Top level of the central-difference gradient block for a 3D scalar volume.
//
// Input stream: in_tuser is the kind (0 writes a sample, 1 queries a voxel);
// in_tdata carries the voxel index and the Q2.14 sample. A write transaction is
// stored in the voxel memory in the cycle it is accepted and yields no result.
// A query transaction yields one result transaction: index, stored scalar and
// three biased normalized gradient components; out_tuser flags an index
// outside the configured volume.
// Configuration writes (cfg_valid/cfg_ready, register index and data) are
// always accepted and must only be issued while no query is in flight.
// A query result is valid after two 15-step coordinate divisions, seven
// memory reads, three 29-step spacing divisions, a 32-step square root and three
// 46-step normalizing divisions on one shared divider and one root unit; a
// zero-length gradient skips the root and the normalizing divisions. An
// out-of-range query skips the divisions and reads; in_tready is low meanwhile.
// A finished result waits in the output register until out_tready is high;
// the next transaction is accepted meanwhile, and a second query holds its
// result until the register frees up.
// Reset clears control state and restores the register defaults; the voxel
// memory is not cleared, and reading a never-written voxel is undefined.
module volume_central_difference_gradient (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // voxel_index [14:0], sample [30:15], zero [31]
  input  logic        in_tuser,   // kind [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_index [14:0], scalar_value [30:15],
                                  // grad_x [46:31], grad_y [62:47], grad_z [78:63], zero [79]
  output logic        out_tuser,  // index_error [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import vcdg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RANGE, S_CHECK, S_COORD_X, S_COORD_Y, S_READ, S_GSTART, S_GWAIT,
    S_SQ, S_SQCHK, S_SQWAIT, S_BSTART, S_BWAIT, S_DONE
  } state_t;

  state_t state_r;

  logic [DIM_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [SP_W-1:0]  spacing_x_r, spacing_y_r, spacing_z_r;

  logic [IDX_W-1:0]  idx_r;
  logic [10:0]       nxy_r;
  logic [4:0]        ix_r, iy_r, iz_r;
  logic [2:0]        cnt_r;
  logic [1:0]        axis_r;
  logic [SMP_W-1:0]  vals_r [7];
  logic [GMAG_W-1:0] gmag_r [3];
  logic [2:0]        gneg_r;
  logic [55:0]       prod_r;
  logic [SUM_W-1:0]  sum_r;
  logic [ROOT_W-1:0] len_r;
  logic [15:0]       grad_r [3];

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [SMP_W-1:0]  out_scalar_r;
  logic [15:0]       out_gx_r, out_gy_r, out_gz_r;
  logic              out_err_r;
  logic              zero_len_r;

  div_req_t  div_req_r;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req_r;
  sqrt_rsp_t sqrt_rsp;

  logic [DIM_W-1:0]  nx, ny, nz;
  logic [IDX_W-1:0]  raddr;
  logic [SMP_W-1:0]  rdata;
  logic              in_acc;
  logic              ram_we;
  logic [SMP_W-1:0]  vm, vp;
  logic [SMP_W:0]    vdiff;
  logic              missing;
  logic [IDX_W-1:0]  mag;
  logic [SP_W-1:0]   sp_sel;
  logic [SP_W-1:0]   sp_eff;
  logic [16:0]       total;

  assign nx = eff_size(size_x_r);
  assign ny = eff_size(size_y_r);
  assign nz = eff_size(size_z_r);

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign ram_we    = in_acc && (in_tuser == KIND_WRITE);

  vcdg_ram #(.WIDTH(SMP_W), .DEPTH(MAX_VOXELS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_tdata[14:0]),
    .wdata (in_tdata[30:15]),
    .raddr (raddr),
    .rdata (rdata)
  );

  vcdg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  vcdg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req_r),
    .rsp   (sqrt_rsp)
  );

  // Neighbour addresses; at a border the voxel itself stands in.
  always_comb begin
    unique case (cnt_r)
      3'd1: raddr = (ix_r == 5'd0) ? idx_r : idx_r - IDX_W'(1);
      3'd2: raddr = (({1'b0, ix_r} + 6'd1) >= nx) ? idx_r : idx_r + IDX_W'(1);
      3'd3: raddr = (iy_r == 5'd0) ? idx_r : idx_r - IDX_W'(nx);
      3'd4: raddr = (({1'b0, iy_r} + 6'd1) >= ny) ? idx_r : idx_r + IDX_W'(nx);
      3'd5: raddr = (iz_r == 5'd0) ? idx_r : idx_r - IDX_W'(nxy_r);
      3'd6: raddr = (({1'b0, iz_r} + 6'd1) >= nz) ? idx_r : idx_r + IDX_W'(nxy_r);
      default: raddr = idx_r;
    endcase
  end

  always_comb begin
    vm = vals_r[{axis_r, 1'b0} + 3'd1];
    vp = vals_r[{axis_r, 1'b0} + 3'd2];
    vdiff = {vp[SMP_W-1], vp} - {vm[SMP_W-1], vm};
    missing = vm[SMP_W-1] || vp[SMP_W-1];
    if (missing) mag = '0;
    else if (vdiff[SMP_W]) mag = IDX_W'(-vdiff);
    else mag = vdiff[IDX_W-1:0];
    unique case (axis_r)
      2'd0:    sp_sel = spacing_x_r;
      2'd1:    sp_sel = spacing_y_r;
      default: sp_sel = spacing_z_r;
    endcase
    sp_eff = (sp_sel == '0) ? SP_W'(1) : sp_sel;
  end

  assign total = 17'(nxy_r) * 17'(nz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= DIM_W'(32);
      size_y_r    <= DIM_W'(32);
      size_z_r    <= DIM_W'(32);
      spacing_x_r <= SP_W'(256);
      spacing_y_r <= SP_W'(256);
      spacing_z_r <= SP_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SIZE_X:    size_x_r    <= cfg_data[DIM_W-1:0];
        CFG_SIZE_Y:    size_y_r    <= cfg_data[DIM_W-1:0];
        CFG_SIZE_Z:    size_z_r    <= cfg_data[DIM_W-1:0];
        CFG_SPACING_X: spacing_x_r <= cfg_data;
        CFG_SPACING_Y: spacing_y_r <= cfg_data;
        CFG_SPACING_Z: spacing_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      div_req_r.start  <= 1'b0;
      sqrt_req_r.start <= 1'b0;
    end else begin
      // Start pulses last one cycle; no state raises one right after another.
      if (div_req_r.start) begin
        div_req_r.start <= 1'b0;
      end
      if (sqrt_req_r.start) begin
        sqrt_req_r.start <= 1'b0;
      end
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_tuser == KIND_QUERY)) begin
            idx_r   <= in_tdata[14:0];
            state_r <= S_RANGE;
          end
        end
        S_RANGE: begin
          nxy_r   <= 11'(nx) * 11'(ny);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          out_err_r <= ({2'b0, idx_r} >= total);
          if ({2'b0, idx_r} >= total) begin
            state_r <= S_DONE;
          end else begin
            div_req_r.start    <= 1'b1;
            div_req_r.steps    <= STEPS_COORD;
            div_req_r.dividend <= DIV_W'(idx_r);
            div_req_r.divisor  <= DVS_W'(nx);
            state_r            <= S_COORD_X;
          end
        end
        S_COORD_X: begin
          if (div_rsp.done) begin
            ix_r               <= div_rsp.rem[4:0];
            div_req_r.start    <= 1'b1;
            div_req_r.steps    <= STEPS_COORD;
            div_req_r.dividend <= DIV_W'(div_rsp.quot[IDX_W-1:0]);
            div_req_r.divisor  <= DVS_W'(ny);
            state_r            <= S_COORD_Y;
          end
        end
        S_COORD_Y: begin
          if (div_rsp.done) begin
            iy_r    <= div_rsp.rem[4:0];
            iz_r    <= div_rsp.quot[4:0];
            cnt_r   <= 3'd0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // Read data arrives in the cycle after its address.
          if (cnt_r != 3'd0) begin
            vals_r[cnt_r - 3'd1] <= rdata;
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            axis_r  <= 2'd0;
            state_r <= S_GSTART;
          end
        end
        S_GSTART: begin
          gneg_r[axis_r]     <= !missing && !vdiff[SMP_W] && (vdiff != '0);
          div_req_r.start    <= 1'b1;
          div_req_r.steps    <= STEPS_GRAD;
          div_req_r.dividend <= DIV_W'({mag, 13'b0}) + DIV_W'(sp_eff[SP_W-1:1]);
          div_req_r.divisor  <= DVS_W'(sp_eff);
          state_r            <= S_GWAIT;
        end
        S_GWAIT: begin
          if (div_rsp.done) begin
            gmag_r[axis_r] <= div_rsp.quot[GMAG_W-1:0];
            if (axis_r == 2'd2) begin
              cnt_r   <= 3'd0;
              state_r <= S_SQ;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= S_GSTART;
            end
          end
        end
        S_SQ: begin
          // One square per cycle, accumulated in the following cycle.
          if (cnt_r != 3'd3) begin
            prod_r <= 56'(gmag_r[cnt_r[1:0]]) * 56'(gmag_r[cnt_r[1:0]]);
          end
          if (cnt_r == 3'd1) sum_r <= SUM_W'(prod_r);
          else if (cnt_r != 3'd0) sum_r <= sum_r + SUM_W'(prod_r);
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            state_r <= S_SQCHK;
          end
        end
        S_SQCHK: begin
          zero_len_r <= (sum_r <= SUM_W'(1));
          if (sum_r <= SUM_W'(1)) begin
            state_r <= S_DONE;
          end else begin
            sqrt_req_r.start <= 1'b1;
            sqrt_req_r.value <= {2'b0, sum_r, 4'b0};
            state_r          <= S_SQWAIT;
          end
        end
        S_SQWAIT: begin
          if (sqrt_rsp.done) begin
            len_r   <= sqrt_rsp.root;
            axis_r  <= 2'd0;
            state_r <= S_BSTART;
          end
        end
        S_BSTART: begin
          div_req_r.start    <= 1'b1;
          div_req_r.steps    <= STEPS_BIAS;
          div_req_r.dividend <= DIV_W'({gmag_r[axis_r], 17'b0}) + DIV_W'(len_r[ROOT_W-1:1]);
          div_req_r.divisor  <= len_r;
          state_r            <= S_BWAIT;
        end
        S_BWAIT: begin
          if (div_rsp.done) begin
            grad_r[axis_r] <= bias_out(div_rsp.quot, gneg_r[axis_r]);
            if (axis_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= S_BSTART;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_index_r <= idx_r;
            if (out_err_r) begin
              out_scalar_r <= '0;
              out_gx_r     <= '0;
              out_gy_r     <= '0;
              out_gz_r     <= '0;
            end else begin
              out_scalar_r <= vals_r[0];
              out_gx_r     <= zero_len_r ? 16'd0 : grad_r[0];
              out_gy_r     <= zero_len_r ? 16'd0 : grad_r[1];
              out_gz_r     <= zero_len_r ? 16'd0 : grad_r[2];
            end
            out_tuser <= out_err_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_CHECK) begin
        zero_len_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_gz_r, out_gy_r, out_gx_r, out_scalar_r, out_index_r};

endmodule

[hdl/vcdg_checker.sv]
// Port-level checker for the volume gradient block and its bind statement.
module vcdg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_data
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Out-of-range queries carry no scalar and no gradient.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[78:15] == 64'd0)
    else $error("index error with nonzero payload");

  // A sample write never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !$rose(out_tvalid))
    else $error("result after a write");

  // A query keeps the input side closed while it is processed.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input accepted during a query");

endmodule

bind volume_central_difference_gradient vcdg_checker u_vcdg_checker (.*);
